// File: src/tcw_pkg.sv
package tcw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;

  localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_CELLS);
  localparam int PROD_W      = $clog2(STORE_CELLS + 1);
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W       = $clog2(MAX_ROWS + 1);
  localparam int CUR_W       = $clog2(MAX_COLUMNS + 8);

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_ATTRIBUTE = 2'd2;

  localparam logic [7:0] COLUMNS_RESET   = 8'd80;
  localparam logic [6:0] ROWS_RESET      = 7'd25;
  localparam logic [7:0] ATTRIBUTE_RESET = 8'd15;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int         TAB_STEP = 8;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_RD0, ST_RD1, ST_PT0, ST_PT1,
    ST_LN, ST_SC0, ST_SCC, ST_SCF, ST_EMIT
  } step_t;

  typedef enum logic [1:0] {MUL_NONE, MUL_TOTAL, MUL_LINE} mul_sel_t;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_CLEAR, MEM_READ, MEM_PUT, MEM_PRIME, MEM_COPY, MEM_FILL
  } mem_op_t;

  typedef enum logic [1:0] {CUR_HOLD, CUR_ADVANCE, CUR_LAST_ROW} cur_op_t;

  typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_INC} idx_op_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_CLEAR_END, C_BEAT, C_READ_OP, C_SCROLL, C_NO_MOVE,
    C_MOVED_END, C_TOTAL_END, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic     in_rdy;
    mul_sel_t mul;
    mem_op_t  mem;
    cur_op_t  cur;
    idx_op_t  idx;
    logic     rdata_ld;
    logic     emit;
    cond_t    cond;
    step_t    on_true;
    step_t    on_false;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c          = '0;
    c.mul      = MUL_NONE;
    c.mem      = MEM_NONE;
    c.cur      = CUR_HOLD;
    c.idx      = IDX_HOLD;
    c.cond     = C_ALWAYS;
    c.on_true  = ST_IDLE;
    c.on_false = ST_IDLE;
    case (s)
      ST_CLEAR: begin
        c.mem = MEM_CLEAR; c.idx = IDX_INC; c.cond = C_CLEAR_END;
        c.on_true = ST_IDLE; c.on_false = ST_CLEAR;
      end
      ST_IDLE: begin
        c.in_rdy = 1'b1; c.cond = C_BEAT;
        c.on_true = ST_DISPATCH; c.on_false = ST_IDLE;
      end
      ST_DISPATCH: begin
        c.mul = MUL_LINE; c.cond = C_READ_OP;
        c.on_true = ST_RD0; c.on_false = ST_PT0;
      end
      ST_RD0: begin
        c.mul = MUL_TOTAL; c.mem = MEM_READ;
        c.on_true = ST_RD1; c.on_false = ST_RD1;
      end
      ST_RD1: begin
        c.rdata_ld = 1'b1;
        c.on_true = ST_EMIT; c.on_false = ST_EMIT;
      end
      ST_PT0: begin
        c.cur = CUR_ADVANCE;
        c.on_true = ST_PT1; c.on_false = ST_PT1;
      end
      ST_PT1: begin
        c.mul = MUL_TOTAL; c.mem = MEM_PUT; c.cond = C_SCROLL;
        c.on_true = ST_SC0; c.on_false = ST_LN;
      end
      ST_LN: begin
        c.mul = MUL_LINE;
        c.on_true = ST_EMIT; c.on_false = ST_EMIT;
      end
      ST_SC0: begin
        c.mem = MEM_PRIME; c.idx = IDX_ZERO; c.cur = CUR_LAST_ROW; c.cond = C_NO_MOVE;
        c.on_true = ST_SCF; c.on_false = ST_SCC;
      end
      ST_SCC: begin
        c.mem = MEM_COPY; c.idx = IDX_INC; c.cond = C_MOVED_END;
        c.on_true = ST_SCF; c.on_false = ST_SCC;
      end
      ST_SCF: begin
        c.mem = MEM_FILL; c.idx = IDX_INC; c.cond = C_TOTAL_END;
        c.on_true = ST_LN; c.on_false = ST_SCF;
      end
      ST_EMIT: begin
        c.emit = 1'b1; c.cond = C_OUT_FREE;
        c.on_true = ST_IDLE; c.on_false = ST_EMIT;
      end
      default: begin
        c.on_true = ST_IDLE; c.on_false = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// File: src/tcw_in_if.sv
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  character;
  logic [12:0] read_address;

  modport source(output valid, opcode, character, read_address, input ready);
  modport sink(input valid, opcode, character, read_address, output ready);
endinterface

// File: src/tcw_out_if.sv
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_column;
  logic [5:0]  cursor_row;
  logic [12:0] cursor_position;
  logic [15:0] read_data;
  logic        scrolled;

  modport source(output valid, cursor_column, cursor_row, cursor_position, read_data,
                 scrolled, input ready);
  modport sink(input valid, cursor_column, cursor_row, cursor_position, read_data,
               scrolled, output ready);
endinterface

// File: src/text_console_cell_writer.sv
// Text console engine with an internal store of attribute:character cells, run by a
// small microcode table. After reset it zeroes all 8192 cells of the store in turn and
// accepts no beat until that pass ends. A read beat runs the dispatch, store read, data
// load and emit steps, a put beat the dispatch, cursor advance, store write, line and
// emit steps; emit waits while the output register is full. A put that scrolls adds
// the scroll steps, because the single-port-write cell store moves the screen up one
// cell per cycle and then fills the bottom row. One beat is worked on at a time; a
// finished result waits in the output register while the next beat is taken.
module text_console_cell_writer (
  input  logic                              clk,
  input  logic                              rst_n,
  tcw_in_if.sink                            in_ch,
  tcw_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int PROD_W = tcw_pkg::PROD_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int CUR_W  = tcw_pkg::CUR_W;

  logic [7:0] cfg_columns_r;
  logic [6:0] cfg_rows_r;
  logic [7:0] cfg_attr_r;

  tcw_pkg::step_t upc_r, upc_nxt;
  tcw_pkg::ctrl_t ctrl;

  logic              op_r;
  logic [7:0]        ch_r;
  logic [12:0]       addr_r;
  logic [COL_W-1:0]  ncol_r, ncol_eff;
  logic [ROW_W-1:0]  nrow_r, nrow_eff;
  logic [CUR_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  line_r, line_nxt;
  logic [CUR_W-1:0]  wcol_r;
  logic              wr_flag_r;
  logic [PROD_W-1:0] total_r, lpos_r, prod, moved;
  logic [ADDR_W-1:0] idx_r;
  logic [15:0]       rdata_r;
  logic              scrolled_r;

  logic [15:0]       store [tcw_pkg::STORE_CELLS];
  logic [15:0]       mem_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  logic              out_valid_r;
  logic [6:0]        out_col_r;
  logic [5:0]        out_row_r;
  logic [12:0]       out_pos_r;
  logic [15:0]       out_rdata_r;
  logic              out_scrolled_r;

  logic in_beat, out_free, cond_ok, cfg_wr, printable;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_columns_r <= tcw_pkg::COLUMNS_RESET;
      cfg_rows_r    <= tcw_pkg::ROWS_RESET;
      cfg_attr_r    <= tcw_pkg::ATTRIBUTE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        tcw_pkg::REG_COLUMNS:   cfg_columns_r <= cfg_pwdata[7:0];
        tcw_pkg::REG_ROWS:      cfg_rows_r    <= cfg_pwdata[6:0];
        tcw_pkg::REG_ATTRIBUTE: cfg_attr_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      tcw_pkg::REG_COLUMNS:   cfg_prdata = {24'd0, cfg_columns_r};
      tcw_pkg::REG_ROWS:      cfg_prdata = {25'd0, cfg_rows_r};
      tcw_pkg::REG_ATTRIBUTE: cfg_prdata = {24'd0, cfg_attr_r};
      default:                cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg_columns_r == 8'd0) begin
      ncol_eff = COL_W'(1);
    end else if (32'(cfg_columns_r) > tcw_pkg::MAX_COLUMNS) begin
      ncol_eff = COL_W'(tcw_pkg::MAX_COLUMNS);
    end else begin
      ncol_eff = COL_W'(cfg_columns_r);
    end
    if (cfg_rows_r == 7'd0) begin
      nrow_eff = ROW_W'(1);
    end else if (32'(cfg_rows_r) > tcw_pkg::MAX_ROWS) begin
      nrow_eff = ROW_W'(tcw_pkg::MAX_ROWS);
    end else begin
      nrow_eff = ROW_W'(cfg_rows_r);
    end
  end

  assign ctrl         = tcw_pkg::ucode(upc_r);
  assign in_ch.ready  = ctrl.in_rdy;
  assign in_beat      = ctrl.in_rdy && in_ch.valid;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign moved        = total_r - PROD_W'(ncol_r);
  assign printable    = ch_r >= tcw_pkg::CH_SPACE;

  always_comb begin
    case (ctrl.cond)
      tcw_pkg::C_ALWAYS:    cond_ok = 1'b1;
      tcw_pkg::C_CLEAR_END: cond_ok = idx_r == ADDR_W'(tcw_pkg::STORE_CELLS - 1);
      tcw_pkg::C_BEAT:      cond_ok = in_beat;
      tcw_pkg::C_READ_OP:   cond_ok = op_r == tcw_pkg::OP_READ;
      tcw_pkg::C_SCROLL:    cond_ok = line_r >= nrow_r;
      tcw_pkg::C_NO_MOVE:   cond_ok = nrow_r == ROW_W'(1);
      tcw_pkg::C_MOVED_END: cond_ok = PROD_W'(idx_r) + PROD_W'(1) == moved;
      tcw_pkg::C_TOTAL_END: cond_ok = PROD_W'(idx_r) + PROD_W'(1) == total_r;
      tcw_pkg::C_OUT_FREE:  cond_ok = out_free;
      default:              cond_ok = 1'b1;
    endcase
    upc_nxt = cond_ok ? ctrl.on_true : ctrl.on_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= tcw_pkg::ST_CLEAR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    case (ch_r)
      tcw_pkg::CH_BS: begin
        if (col_r != '0) begin
          col_nxt = col_r - CUR_W'(1);
        end
      end
      tcw_pkg::CH_TAB: begin
        col_nxt = (col_r + CUR_W'(tcw_pkg::TAB_STEP)) & ~CUR_W'(tcw_pkg::TAB_STEP - 1);
      end
      tcw_pkg::CH_CR: begin
        col_nxt = '0;
      end
      tcw_pkg::CH_LF: begin
        col_nxt  = '0;
        line_nxt = line_r + ROW_W'(1);
      end
      default: begin
        if (printable) begin
          col_nxt = col_r + CUR_W'(1);
        end
      end
    endcase
    if (col_nxt >= CUR_W'(ncol_r)) begin
      col_nxt  = '0;
      line_nxt = line_nxt + ROW_W'(1);
    end
  end

  always_comb begin
    if (ctrl.mul == tcw_pkg::MUL_TOTAL) begin
      prod = PROD_W'(nrow_r) * PROD_W'(ncol_r);
    end else begin
      prod = PROD_W'(line_r) * PROD_W'(ncol_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      line_r     <= '0;
      idx_r      <= '0;
      scrolled_r <= 1'b0;
      rdata_r    <= '0;
    end else begin
      if (in_beat) begin
        scrolled_r <= 1'b0;
        rdata_r    <= '0;
      end
      case (ctrl.cur)
        tcw_pkg::CUR_ADVANCE: begin
          col_r  <= col_nxt;
          line_r <= line_nxt;
        end
        tcw_pkg::CUR_LAST_ROW: begin
          line_r     <= nrow_r - ROW_W'(1);
          scrolled_r <= 1'b1;
        end
        default: ;
      endcase
      case (ctrl.idx)
        tcw_pkg::IDX_ZERO: idx_r <= '0;
        tcw_pkg::IDX_INC:  idx_r <= idx_r + ADDR_W'(1);
        default: ;
      endcase
      if (ctrl.rdata_ld) begin
        rdata_r <= (32'(addr_r) < 32'(total_r)) ? mem_q : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r   <= in_ch.opcode;
      ch_r   <= in_ch.character;
      addr_r <= in_ch.read_address;
      ncol_r <= ncol_eff;
      nrow_r <= nrow_eff;
    end
    if (ctrl.cur == tcw_pkg::CUR_ADVANCE) begin
      wcol_r    <= col_r;
      wr_flag_r <= printable && (col_r < CUR_W'(ncol_r)) && (line_r < nrow_r);
    end
    case (ctrl.mul)
      tcw_pkg::MUL_TOTAL: total_r <= prod;
      tcw_pkg::MUL_LINE:  lpos_r  <= prod;
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_r;
    mem_raddr = idx_r;
    mem_wdata = '0;
    case (ctrl.mem)
      tcw_pkg::MEM_CLEAR: begin
        mem_we = 1'b1;
      end
      tcw_pkg::MEM_READ: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(addr_r);
      end
      tcw_pkg::MEM_PUT: begin
        mem_we    = wr_flag_r;
        mem_waddr = ADDR_W'(lpos_r + PROD_W'(wcol_r));
        mem_wdata = {cfg_attr_r, ch_r};
      end
      tcw_pkg::MEM_PRIME: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(ncol_r);
      end
      tcw_pkg::MEM_COPY: begin
        mem_we    = 1'b1;
        mem_wdata = mem_q;
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(PROD_W'(idx_r) + PROD_W'(ncol_r) + PROD_W'(1));
      end
      tcw_pkg::MEM_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {cfg_attr_r, tcw_pkg::CH_SPACE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= store[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      out_col_r      <= 7'(col_r);
      out_row_r      <= 6'(line_r);
      out_pos_r      <= 13'(lpos_r + PROD_W'(col_r));
      out_rdata_r    <= rdata_r;
      out_scrolled_r <= scrolled_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_column   = out_col_r;
  assign out_ch.cursor_row      = out_row_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.read_data       = out_rdata_r;
  assign out_ch.scrolled        = out_scrolled_r;

endmodule

// File: dv/tb.sv
module tb;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [5:0]  cursor_row;
    logic [12:0] cursor_position;
    logic [15:0] read_data;
    logic        scrolled;
  } cursor_report_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [tcw_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  text_console_cell_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  logic [15:0]    screen_cells [tcw_pkg::STORE_CELLS];
  int             cur_col;
  int             cur_row;
  logic [7:0]     reg_columns;
  logic [6:0]     reg_rows;
  logic [7:0]     reg_attr;
  cursor_report_t pending_reports [$];
  int             error_count = 0;
  int             cycle_count = 0;
  bit             gaps_on;
  bit             offering;
  logic           hold_go;
  int             hold_left = 0;
  int             beat_wait = 0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int clamp_dim(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic advance_console(input logic op, input logic [7:0] ch, input logic [12:0] addr,
                                 output cursor_report_t r);
    int ncol;
    int nrow;
    int col;
    int row;
    int pos;
    int i;
    r = '0;
    ncol = clamp_dim(reg_columns, tcw_pkg::MAX_COLUMNS);
    nrow = clamp_dim(reg_rows, tcw_pkg::MAX_ROWS);
    if (op == tcw_pkg::OP_READ) begin
      if (addr < ncol * nrow) r.read_data = screen_cells[addr];
    end else begin
      col = cur_col;
      row = cur_row;
      if (ch == tcw_pkg::CH_BS) begin
        if (col != 0) col--;
      end else if (ch == tcw_pkg::CH_TAB) begin
        col = (col + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
      end else if (ch == tcw_pkg::CH_CR) begin
        col = 0;
      end else if (ch == tcw_pkg::CH_LF) begin
        col = 0;
        row++;
      end else if (ch >= tcw_pkg::CH_SPACE) begin
        if (col < ncol && row < nrow) screen_cells[row * ncol + col] = {reg_attr, ch};
        col++;
      end
      if (col >= ncol) begin
        col = 0;
        row++;
      end
      cur_col = col;
      cur_row = row;
      if (row >= nrow) begin
        for (i = 0; i < (nrow - 1) * ncol; i++) screen_cells[i] = screen_cells[i + ncol];
        for (i = (nrow - 1) * ncol; i < nrow * ncol; i++) begin
          screen_cells[i] = {reg_attr, tcw_pkg::CH_SPACE};
        end
        cur_row = nrow - 1;
        r.scrolled = 1'b1;
      end
    end
    pos = cur_row * ncol + cur_col;
    r.cursor_column   = cur_col[6:0];
    r.cursor_row      = cur_row[5:0];
    r.cursor_position = pos[12:0];
  endtask

  // Result side: checks each beat, then stalls at random while gaps are on, or for a requested hold.
  always @(posedge clk) begin : result_side
    cursor_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no expected result");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("cursor_column", want.cursor_column, out_ch.cursor_column);
        check_field("cursor_row", want.cursor_row, out_ch.cursor_row);
        check_field("cursor_position", want.cursor_position, out_ch.cursor_position);
        check_field("read_data", want.read_data, out_ch.read_data);
        check_field("scrolled", want.scrolled, out_ch.scrolled);
      end
      beat_wait = gaps_on ? $urandom_range(0, 8) : 0;
    end
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (beat_wait > 0) begin
      beat_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] ch, input logic [12:0] addr);
    int gap;
    cursor_report_t r;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      if (offering) in_ch.valid <= 1'b0;
      offering = 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.character    <= ch;
    in_ch.read_address <= addr;
    offering = 1;
    do @(posedge clk); while (!in_ch.ready);
    advance_console(op, ch, addr, r);
    pending_reports.push_back(r);
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_item(tcw_pkg::OP_PUT, ch, 13'($urandom_range(0, 8191)));
  endtask

  task automatic read_cell(input logic [12:0] addr);
    send_item(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)), addr);
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 0;
    end
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] got;
    logic [31:0] ignored;
    apb_access(1'b1, idx, value, ignored);
    case (idx)
      tcw_pkg::REG_COLUMNS: begin
        reg_columns = value[7:0];
        mask = 32'hFF;
      end
      tcw_pkg::REG_ROWS: begin
        reg_rows = value[6:0];
        mask = 32'h7F;
      end
      default: begin
        reg_attr = value[7:0];
        mask = 32'hFF;
      end
    endcase
    apb_access(1'b0, idx, 32'd0, got);
    if (got !== (value & mask)) begin
      $error("register %0d: expected %0h, got %0h", idx, value & mask, got);
      error_count++;
    end
  endtask

  task automatic set_screen(input int cols, input int rows, input int attr);
    wait_drained();
    set_reg(tcw_pkg::REG_COLUMNS, cols);
    set_reg(tcw_pkg::REG_ROWS, rows);
    set_reg(tcw_pkg::REG_ATTRIBUTE, attr);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_cursor_controls();
    read_cell(13'd0);
    read_cell(13'd8191);
    put_char(8'h41);
    put_char(8'hFF);
    put_char(tcw_pkg::CH_BS);
    put_char(tcw_pkg::CH_BS);
    put_char(tcw_pkg::CH_BS);
    put_char(tcw_pkg::CH_TAB);
    put_char(8'h00);
    put_char(8'h1F);
    put_char(tcw_pkg::CH_CR);
    put_char(tcw_pkg::CH_LF);
    read_cell(13'd1);
  endtask

  task automatic test_wrap_and_scroll();
    set_screen(0, 0, 8'h5A);
    put_char(8'h78);
    read_cell(13'd0);
    set_screen(12, 2, 0);
    put_char(8'h61);
    put_char(tcw_pkg::CH_TAB);
    put_char(tcw_pkg::CH_TAB);
    put_char(tcw_pkg::CH_LF);
    read_cell(13'd0);
  endtask

  // The cursor is left at column 32 on a full-size screen, then the screen shrinks under it to 16 columns.
  task automatic test_off_screen_cursor();
    set_screen(255, 127, 8'hFF);
    repeat (4) put_char(tcw_pkg::CH_TAB);
    set_screen(16, 1, 8'h3C);
    read_cell(13'd0);
    put_char(8'h7A);
    read_cell(13'd0);
  endtask

  task automatic test_backpressure();
    set_screen(20, 6, $urandom_range(0, 255));
    gaps_on = 0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (24) put_char(8'($urandom_range(0, 255)));
    wait_drained();
    gaps_on = 1;
  endtask

  task automatic run_screen_phase(input int n, input int cols, input int rows, input int attr);
    int sel;
    int cells;
    logic [7:0] ch;
    set_screen(cols, rows, attr);
    cells = clamp_dim(reg_columns, tcw_pkg::MAX_COLUMNS) * clamp_dim(reg_rows, tcw_pkg::MAX_ROWS);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        if ($urandom_range(0, 3) == 0) read_cell(13'($urandom_range(0, 8191)));
        else read_cell(13'($urandom_range(0, cells - 1)));
      end else if (sel < 32) begin
        case ($urandom_range(0, 3))
          0: ch = tcw_pkg::CH_BS;
          1: ch = tcw_pkg::CH_TAB;
          2: ch = tcw_pkg::CH_CR;
          default: ch = tcw_pkg::CH_LF;
        endcase
        put_char(ch);
      end else if (sel < 37) begin
        put_char(8'($urandom_range(0, 31)));
      end else begin
        put_char(8'($urandom_range(32, 255)));
      end
    end
  endtask

  task automatic test_random_screens();
    run_screen_phase(150, tcw_pkg::COLUMNS_RESET, tcw_pkg::ROWS_RESET, tcw_pkg::ATTRIBUTE_RESET);
    run_screen_phase(80, 1, 64, 0);
    run_screen_phase(80, 128, 1, 255);
    run_screen_phase(60, 0, 0, $urandom_range(0, 255));
    run_screen_phase(40, 255, 127, $urandom_range(0, 255));
    repeat (6) begin
      run_screen_phase(70, $urandom_range(1, 20), $urandom_range(1, 8), $urandom_range(0, 255));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = tcw_pkg::OP_PUT;
    in_ch.character = 8'd0;
    in_ch.read_address = 13'd0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_go = 1'b0;
    for (int i = 0; i < tcw_pkg::STORE_CELLS; i++) screen_cells[i] = 16'd0;
    cur_col = 0;
    cur_row = 0;
    reg_columns = tcw_pkg::COLUMNS_RESET;
    reg_rows = tcw_pkg::ROWS_RESET;
    reg_attr = tcw_pkg::ATTRIBUTE_RESET;
    gaps_on = 1;
    offering = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_cursor_controls();
    test_wrap_and_scroll();
    test_off_screen_cursor();
    test_backpressure();
    test_random_screens();

    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
